// File: hdl/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer package
// Screen geometry, payload structs, command and sequencer codes.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int CARET_W    = 11;

  localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY    = ADDR_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FIRST_BOTTOM = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);

  localparam logic [7:0] CODE_BACKSPACE = 8'h08;
  localparam logic [7:0] CODE_TAB       = 8'h09;
  localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [7:0] BLANK_CHAR     = 8'h20;
  localparam logic [7:0] RESET_COLOR    = 8'h07;
  localparam logic [15:0] RESET_CELL    = {RESET_COLOR, BLANK_CHAR};

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
    logic [10:0] caret_index;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_READ,
    OP_PUT,
    OP_TAB,
    OP_NEWLINE,
    OP_BACKSPACE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  ch;
    logic [10:0] idx;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRINT,
    ST_LINE,
    ST_BACK,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_t;

endpackage

// File: hdl/tccw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console front end
// Accepts input beats, decodes them into commands and queues up to two of them.
// ----------------------------------------------------------------------------
module tccw_front import tccw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     clearing,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       decoded;
  logic       push;

  always_comb begin
    decoded.ch  = in_data.char_code;
    decoded.idx = in_data.cell_index;
    if (in_data.kind == KIND_READ) begin
      decoded.op = OP_READ;
    end else begin
      case (in_data.char_code)
        CODE_BACKSPACE: decoded.op = OP_BACKSPACE;
        CODE_TAB:       decoded.op = OP_TAB;
        CODE_NEWLINE:   decoded.op = OP_NEWLINE;
        default:        decoded.op = OP_PUT;
      endcase
    end
  end

  assign in_ready  = !clearing && (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// File: hdl/tccw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console back end
// Sequencer that owns the screen memory and cursor and executes commands.
// ----------------------------------------------------------------------------
module tccw_back import tccw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      clearing,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [15:0] screen [CELL_COUNT];
  logic [15:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;

  state_t            state, state_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [2:0]        cnt, cnt_next;
  logic [7:0]        ch, ch_next;
  logic [ADDR_W-1:0] scan, scan_next;
  logic              read_hit, read_hit_next;
  logic              wr_en, wr_en_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic              wr_from_mem, wr_from_mem_next;
  logic [15:0]       wr_cell, wr_cell_next;
  logic              res_valid, res_valid_next;
  out_item_t         res, res_next;
  logic [7:0]        text_color;
  logic [ADDR_W-1:0] cur_idx;
  logic              in_range;

  assign cur_idx  = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  assign in_range = 32'(cmd.idx) < CELL_COUNT;
  assign clearing = (state == ST_CLEAR);
  assign out_valid = res_valid;
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      screen[wr_addr] <= wr_from_mem ? rd_data : wr_cell;
    end
    rd_data <= screen[rd_addr];
  end

  always_comb begin
    state_next       = state;
    row_next         = row;
    col_next         = col;
    cnt_next         = cnt;
    ch_next          = ch;
    scan_next        = scan;
    read_hit_next    = read_hit;
    wr_en_next       = 1'b0;
    wr_addr_next     = wr_addr;
    wr_from_mem_next = 1'b0;
    wr_cell_next     = wr_cell;
    res_next         = res;
    res_valid_next   = res_valid && !out_ready;
    cmd_pop          = 1'b0;
    rd_addr          = ADDR_W'(cmd.idx);
    case (state)
      ST_CLEAR: begin
        wr_en_next   = 1'b1;
        wr_addr_next = scan;
        wr_cell_next = RESET_CELL;
        if (scan == LAST_CELL) begin
          scan_next  = '0;
          state_next = ST_IDLE;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid && !res_valid) begin
          cmd_pop       = 1'b1;
          read_hit_next = 1'b0;
          case (cmd.op)
            OP_READ: begin
              read_hit_next = in_range;
              state_next    = ST_DONE;
            end
            OP_PUT: begin
              cnt_next   = 3'd1;
              ch_next    = cmd.ch;
              state_next = ST_PRINT;
            end
            OP_TAB: begin
              cnt_next   = 3'd4 - {1'b0, col[1:0]};
              ch_next    = BLANK_CHAR;
              state_next = ST_PRINT;
            end
            OP_NEWLINE: begin
              cnt_next   = 3'd0;
              state_next = ST_LINE;
            end
            OP_BACKSPACE: state_next = ST_BACK;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_PRINT: begin
        wr_en_next   = 1'b1;
        wr_addr_next = cur_idx;
        wr_cell_next = {text_color, ch};
        cnt_next     = cnt - 1'b1;
        state_next   = (cnt == 3'd1) ? ST_DONE : ST_PRINT;
        if (col == LAST_COL) begin
          col_next = '0;
          if (row == LAST_ROW) begin
            scan_next  = '0;
            state_next = ST_SCROLL;
          end else begin
            row_next = row + 1'b1;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
      ST_LINE: begin
        col_next = '0;
        if (row == LAST_ROW) begin
          scan_next  = '0;
          state_next = ST_SCROLL;
        end else begin
          row_next   = row + 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_BACK: begin
        state_next = ST_DONE;
        if (col != '0 || row != '0) begin
          wr_en_next   = 1'b1;
          wr_addr_next = cur_idx - 1'b1;
          wr_cell_next = {text_color, BLANK_CHAR};
          if (col == '0) begin
            row_next = row - 1'b1;
            col_next = LAST_COL;
          end else begin
            col_next = col - 1'b1;
          end
        end
      end
      ST_SCROLL: begin
        rd_addr          = scan + ADDR_W'(COLUMNS);
        wr_en_next       = 1'b1;
        wr_addr_next     = scan;
        wr_from_mem_next = 1'b1;
        if (scan == LAST_COPY) begin
          scan_next  = FIRST_BOTTOM;
          state_next = ST_BLANK;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      ST_BLANK: begin
        wr_en_next   = 1'b1;
        wr_addr_next = scan;
        wr_cell_next = {text_color, BLANK_CHAR};
        if (scan == LAST_CELL) begin
          state_next = (cnt != 3'd0) ? ST_PRINT : ST_DONE;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      ST_DONE: begin
        res_valid_next          = 1'b1;
        res_next.cell_value     = read_hit ? rd_data : 16'h0000;
        res_next.cursor_row_out = 5'(row);
        res_next.cursor_col_out = 7'(col);
        res_next.caret_index    = CARET_W'(cur_idx);
        state_next              = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      row        <= '0;
      col        <= '0;
      cnt        <= '0;
      scan       <= '0;
      read_hit   <= 1'b0;
      wr_en      <= 1'b0;
      res_valid  <= 1'b0;
      text_color <= RESET_COLOR;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      cnt       <= cnt_next;
      scan      <= scan_next;
      read_hit  <= read_hit_next;
      wr_en     <= wr_en_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch          <= ch_next;
    wr_addr     <= wr_addr_next;
    wr_from_mem <= wr_from_mem_next;
    wr_cell     <= wr_cell_next;
    res         <= res_next;
  end

  a_pop_needs_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !res_valid)
    else $error("command taken while a result is still held");

  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> res_valid)
    else $error("finished command produced no result");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(row) < ROWS && 32'(col) < COLUMNS)
    else $error("cursor left the screen");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cmd_pop)
    else $error("command taken during the clearing pass");

endmodule

// File: hdl/text_console_char_writer.sv
`timescale 1ns / 1ps
// A read command goes from the front-end queue to the idle state and on to the done state,
// which registers the result; other commands first pass their print, line or back state.
// The sequencer takes a new command only when idle with no result held, while the front end
// queues up to two beats. A scroll copies the rows up and blanks the bottom row, one cell
// copied or blanked per cycle. Reset is synchronous; afterwards a clearing pass fills the
// screen with grey spaces, and no input beat is taken until it ends.
// ----------------------------------------------------------------------------
// Text console character writer
// Text screen with cursor, printing, tab, newline, backspace, scroll and readback.
// ----------------------------------------------------------------------------
module text_console_char_writer import tccw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic clearing;

  tccw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tccw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
